// ----- rtl/core/stt_pkg.sv -----
`default_nettype none

package stt_pkg;

   // slot table
   localparam int SLOT_COUNT = 8;
   localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int WALK_BITS  = SLOT_BITS;

   // field widths
   localparam int ID_W     = 16;
   localparam int MS_W     = 32;
   localparam int REP_W    = 8;
   localparam int PERIOD_W = 29;
   localparam int TIME_W   = 32;

   // stream widths
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 40;

   // command codes
   localparam logic [2:0] MODE_SET   = 3'd0;
   localparam logic [2:0] MODE_KILL  = 3'd1;
   localparam logic [2:0] MODE_QUERY = 3'd2;
   localparam logic [2:0] MODE_TICK  = 3'd3;
   localparam logic [2:0] MODE_SCAN  = 3'd4;

   localparam logic signed [REP_W-1:0] REPEAT_FOREVER = -8'sd1;

   // ceil(ms/10): radix-16 long division by ten, one nibble per cycle
   localparam int DIV_W       = 36;
   localparam int DIV_STEPS   = DIV_W / 4;
   localparam int DIV_BITS    = 4;
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int ROUND_UP    = 9;

   typedef struct packed {
      logic [2:0]                mode;
      logic [ID_W-1:0]           timer_id;
      logic [PERIOD_W-1:0]       period;
      logic signed [REP_W-1:0]   repeat_count;
   } cmd_type;

   typedef struct packed {
      logic [4:0]       pad;
      logic [ID_W-1:0]  fired_id;
      logic             fired;
      logic             running;
      logic [ID_W-1:0]  result_id;
      logic             status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/soft_timer_table_unit.sv -----
// Software timer table: eight slots keyed by a nonzero 16-bit id, run off a
// 32-bit tick counter. Each request word carries one command (set, kill,
// query, tick or scan) and yields exactly one response word, in order. Set
// arms the slot already holding the id, else the first disabled one, with a
// period of ceil(ms/10) ticks; scan fires at most one expired slot, starting
// from a round-robin pointer. Timing: the front end takes a word and queues
// every command but set in that same cycle; a set then runs through the
// divide-by-ten unit (one nibble a cycle) and is queued from a push state
// that waits while the queue is full, and the front end is busy until then.
// The back end pops a word, walks all 8 slots, one per cycle, for set, kill,
// query and scan, then updates the table and loads the response register
// once that register is free; a tick or an unused mode skips the walk.
// A two-entry queue lets the divider run ahead of the walk, and the response
// register lets the next walk start while a response waits to be taken.
`default_nettype none

module soft_timer_table_unit
   import stt_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // [2:0] mode
   input  wire [REQ_USER_W-1:0]   req_tuser,
   // [15:0] timer_id, [47:16] duration_ms, [55:48] repeat_count
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [0] status, [16:1] result_id, [17] running, [18] fired, [34:19] fired_id
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // front end -> queue
   logic      push_valid;
   cmd_type   push_cmd;
   logic      queue_full;

   // queue -> back end
   logic      queue_empty;
   logic      cmd_pop;
   cmd_type   pop_cmd;

   // decodes commands and computes the tick period for set
   stt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   stt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (cmd_pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   // owns the slot table, time counter, scan pointer and response register
   stt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (!queue_empty),
      .cmd        (pop_cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- rtl/core/stt_front.sv -----
`default_nettype none

module stt_front
   import stt_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [REQ_USER_W-1:0]   req_tuser,
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   output logic                   push_valid,
   output cmd_type                push_cmd,
   input  wire                    queue_full
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in, in_cmd;
   logic [DIV_W-1:0]      div_ff, div_in, quot_ff, quot_in;
   logic [3:0]            rem_ff, rem_in;
   logic [DIV_BITS-1:0]   cnt_ff, cnt_in;
   logic [7:0]            step_x, step_r;
   logic [15:0]           step_prod;
   logic [3:0]            step_q;
   logic                  accept;

   always_comb begin
      // one long-division digit: x < 160, so the reciprocal product is exact
      step_x    = {rem_ff, div_ff[DIV_W-1 -: 4]};
      step_prod = 16'(step_x) * 16'(DIV10_MUL);
      step_q    = step_prod[DIV10_SHIFT +: 4];
      step_r    = step_x - (8'(step_q) * 8'd10);

      in_cmd.mode         = req_tuser[2:0];
      in_cmd.timer_id     = req_tdata[ID_W-1:0];
      in_cmd.period       = '0;
      in_cmd.repeat_count = req_tdata[ID_W+MS_W +: REP_W];

      req_tready = (state_ff == ST_IDLE) && !queue_full;
      accept     = req_tvalid && req_tready;

      state_in   = state_ff;
      cmd_in     = cmd_ff;
      div_in     = div_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      push_valid = 1'b0;
      push_cmd   = in_cmd;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_cmd.mode == MODE_SET) begin
                  cmd_in   = in_cmd;
                  div_in   = DIV_W'(33'(req_tdata[ID_W +: MS_W]) + 33'(ROUND_UP));
                  quot_in  = '0;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  push_valid = 1'b1;
               end
            end
         end
         ST_DIV: begin
            div_in  = div_ff << 4;
            rem_in  = step_r[3:0];
            quot_in = {quot_ff[DIV_W-5:0], step_q};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == DIV_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            push_cmd        = cmd_ff;
            push_cmd.period = quot_ff[PERIOD_W-1:0];
            if (!queue_full) begin
               push_valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/stt_queue.sv -----
`default_nettype none

module stt_queue
   import stt_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  wire      pop,
   output cmd_type  pop_cmd,
   output logic     empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   always_comb begin
      full      = (count_ff == (PTR_W+1)'(DEPTH));
      empty     = (count_ff == '0);
      pop_cmd   = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/stt_back.sv -----
`default_nettype none

module stt_back
   import stt_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    cmd_valid,
   input  cmd_type                cmd,
   output logic                   cmd_pop,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_COMMIT} state_type;

   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;

   // slot table
   logic                      slot_en_ff  [SLOT_COUNT];
   logic                      slot_en_in  [SLOT_COUNT];
   logic [ID_W-1:0]           slot_key_ff [SLOT_COUNT];
   logic [ID_W-1:0]           slot_key_in [SLOT_COUNT];
   logic [PERIOD_W-1:0]       slot_per_ff [SLOT_COUNT];
   logic [PERIOD_W-1:0]       slot_per_in [SLOT_COUNT];
   logic [TIME_W-1:0]         slot_dl_ff  [SLOT_COUNT];
   logic [TIME_W-1:0]         slot_dl_in  [SLOT_COUNT];
   logic signed [REP_W-1:0]   slot_rep_ff [SLOT_COUNT];
   logic signed [REP_W-1:0]   slot_rep_in [SLOT_COUNT];

   logic [SLOT_BITS-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [TIME_W-1:0]         time_ff, time_in;

   // walk and what it found
   logic [SLOT_BITS-1:0]      walk_idx_ff, walk_idx_in;
   logic [WALK_BITS-1:0]      walk_cnt_ff, walk_cnt_in;
   logic                      match_hit_ff, match_hit_in, match_en_ff, match_en_in;
   logic [SLOT_BITS-1:0]      match_idx_ff, match_idx_in;
   logic                      free_hit_ff, free_hit_in;
   logic [SLOT_BITS-1:0]      free_idx_ff, free_idx_in;
   logic                      fire_hit_ff, fire_hit_in;
   logic [SLOT_BITS-1:0]      fire_idx_ff, fire_idx_in;
   logic [ID_W-1:0]           fire_key_ff, fire_key_in;
   logic [PERIOD_W-1:0]       fire_per_ff, fire_per_in;
   logic signed [REP_W-1:0]   fire_rep_ff, fire_rep_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      rd_en;
   logic [ID_W-1:0]           rd_key;
   logic [TIME_W-1:0]         rd_dl;
   logic                      out_free, id_ok, set_ok, still_en;
   logic [SLOT_BITS-1:0]      set_idx;

   function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] idx);
      logic [SLOT_BITS-1:0] nxt;
      if (idx == SLOT_BITS'(SLOT_COUNT - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

   always_comb begin
      rd_en  = slot_en_ff[walk_idx_ff];
      rd_key = slot_key_ff[walk_idx_ff];
      rd_dl  = slot_dl_ff[walk_idx_ff];

      out_free = !rsp_valid_ff || rsp_tready;
      id_ok    = (cmd_ff.timer_id != '0);
      set_ok   = id_ok && (cmd_ff.period != '0) && (match_hit_ff || free_hit_ff);
      set_idx  = match_hit_ff ? match_idx_ff : free_idx_ff;
      still_en = (fire_rep_ff == REPEAT_FOREVER) || (fire_rep_ff > 0);

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      slot_en_in   = slot_en_ff;
      slot_key_in  = slot_key_ff;
      slot_per_in  = slot_per_ff;
      slot_dl_in   = slot_dl_ff;
      slot_rep_in  = slot_rep_ff;
      scan_ptr_in  = scan_ptr_ff;
      time_in      = time_ff;
      walk_idx_in  = walk_idx_ff;
      walk_cnt_in  = walk_cnt_ff;
      match_hit_in = match_hit_ff;
      match_en_in  = match_en_ff;
      match_idx_in = match_idx_ff;
      free_hit_in  = free_hit_ff;
      free_idx_in  = free_idx_ff;
      fire_hit_in  = fire_hit_ff;
      fire_idx_in  = fire_idx_ff;
      fire_key_in  = fire_key_ff;
      fire_per_in  = fire_per_ff;
      fire_rep_in  = fire_rep_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd_pop      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               cmd_in       = cmd;
               walk_idx_in  = (cmd.mode == MODE_SCAN) ? scan_ptr_ff : '0;
               walk_cnt_in  = '0;
               match_hit_in = 1'b0;
               free_hit_in  = 1'b0;
               fire_hit_in  = 1'b0;
               if (cmd.mode inside {MODE_SET, MODE_KILL, MODE_QUERY, MODE_SCAN}) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_WALK: begin
            if (rd_key == cmd_ff.timer_id && !match_hit_ff) begin
               match_hit_in = 1'b1;
               match_idx_in = walk_idx_ff;
               match_en_in  = rd_en;
            end
            if (!rd_en && !free_hit_ff) begin
               free_hit_in = 1'b1;
               free_idx_in = walk_idx_ff;
            end
            if (cmd_ff.mode == MODE_SCAN && rd_en && time_ff >= rd_dl && !fire_hit_ff) begin
               fire_hit_in = 1'b1;
               fire_idx_in = walk_idx_ff;
               fire_key_in = rd_key;
               fire_per_in = slot_per_ff[walk_idx_ff];
               fire_rep_in = slot_rep_ff[walk_idx_ff];
            end
            walk_idx_in = next_slot(walk_idx_ff);
            walk_cnt_in = walk_cnt_ff + 1'b1;
            if (walk_cnt_ff == WALK_BITS'(SLOT_COUNT - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               case (cmd_ff.mode)
                  MODE_SET: begin
                     if (set_ok) begin
                        slot_en_in[set_idx]  = 1'b1;
                        slot_key_in[set_idx] = cmd_ff.timer_id;
                        slot_per_in[set_idx] = cmd_ff.period;
                        slot_dl_in[set_idx]  = time_ff + TIME_W'(cmd_ff.period);
                        slot_rep_in[set_idx] = cmd_ff.repeat_count;
                        rsp_in.result_id     = cmd_ff.timer_id;
                     end else begin
                        rsp_in.status = 1'b1;
                     end
                  end
                  MODE_KILL: begin
                     if (id_ok && match_hit_ff) begin
                        slot_en_in[match_idx_ff] = 1'b0;
                        rsp_in.result_id         = cmd_ff.timer_id;
                     end else begin
                        rsp_in.status = 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     rsp_in.running = id_ok && match_hit_ff && match_en_ff;
                  end
                  MODE_TICK: begin
                     time_in = time_ff + 1'b1;
                  end
                  MODE_SCAN: begin
                     if (fire_hit_ff) begin
                        if (fire_rep_ff > 0) begin
                           slot_rep_in[fire_idx_ff] = fire_rep_ff - 1'b1;
                        end
                        if (still_en) begin
                           slot_dl_in[fire_idx_ff] = time_ff + TIME_W'(fire_per_ff);
                        end else begin
                           slot_en_in[fire_idx_ff] = 1'b0;
                        end
                        scan_ptr_in     = next_slot(fire_idx_ff);
                        rsp_in.fired    = 1'b1;
                        rsp_in.fired_id = fire_key_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_ptr_ff  <= '0;
         time_ff      <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_en_ff[i]  <= 1'b0;
            slot_key_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ptr_ff  <= scan_ptr_in;
         time_ff      <= time_in;
         slot_en_ff   <= slot_en_in;
         slot_key_ff  <= slot_key_in;
      end
      slot_per_ff  <= slot_per_in;
      slot_dl_ff   <= slot_dl_in;
      slot_rep_ff  <= slot_rep_in;
      cmd_ff       <= cmd_in;
      walk_idx_ff  <= walk_idx_in;
      walk_cnt_ff  <= walk_cnt_in;
      match_hit_ff <= match_hit_in;
      match_en_ff  <= match_en_in;
      match_idx_ff <= match_idx_in;
      free_hit_ff  <= free_hit_in;
      free_idx_ff  <= free_idx_in;
      fire_hit_ff  <= fire_hit_in;
      fire_idx_ff  <= fire_idx_in;
      fire_key_ff  <= fire_key_in;
      fire_per_ff  <= fire_per_in;
      fire_rep_ff  <= fire_rep_in;
      rsp_ff       <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/stt_checker.sv -----
`default_nettype none

module stt_checker
   import stt_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire [RSP_DATA_W-1:0]   rsp_tdata
);

   rsp_type rsp;

   assign rsp = rsp_tdata;

   // a stalled response word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // an error carries no id and no fire
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.status |-> rsp.result_id == '0 && !rsp.fired && !rsp.running)
      else $error("error response with payload");

   // a fire comes only from a scan, so no other answer rides with it
   a_fire_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.fired |-> rsp.result_id == '0 && !rsp.running && !rsp.status)
      else $error("fired response mixed with other answers");

   // fired_id is only shown with a fire, and a fired slot never has id zero
   a_fire_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.fired == (rsp.fired_id != '0))
      else $error("fired_id inconsistent with fired");

   // padding stays zero
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.pad == '0)
      else $error("response padding not zero");

endmodule

bind soft_timer_table_unit stt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
